// File: sv/hc128_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HC-128 package
// Shared transaction types, constants, state encoding and mixing functions.
// ----------------------------------------------------------------------------
package hc128_pkg;

    localparam int TBL_DEPTH   = 512;
    localparam int TBL_AW      = 9;
    localparam int WORD_W      = 32;
    localparam int CFG_W       = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [10:0] SCHED_FIRST = 11'd16;
    localparam logic [10:0] SCHED_LAST  = 11'd1279;
    localparam logic [10:0] P_FIRST     = 11'd256;
    localparam logic [10:0] Q_FIRST     = 11'd768;
    localparam logic [9:0]  STEP_LAST   = 10'd1023;

    localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [1:0] CFG_IV_LOW   = 2'd2;
    localparam logic [1:0] CFG_IV_HIGH  = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       init_done;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCHED,
        ST_STEP
    } state_t;

    typedef enum logic [3:0] {
        PH_RD_A,
        PH_RD_B,
        PH_RD_C,
        PH_RD_T,
        PH_RD_X,
        PH_CAP_X,
        PH_RD_UA,
        PH_RD_UB,
        PH_WRITE
    } phase_t;

    function automatic logic [31:0] sig1(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig2(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    function automatic logic [31:0] mixp(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c);
        return ({a[9:0], a[31:10]} ^ {c[22:0], c[31:23]}) + {b[7:0], b[31:8]};
    endfunction

    function automatic logic [31:0] mixq(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c);
        return ({a[21:0], a[31:22]} ^ {c[8:0], c[31:9]}) + {b[23:0], b[31:24]};
    endfunction

endpackage
`default_nettype wire

// File: sv/hc128_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HC-128 generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module hc128_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: sv/hc128_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HC-128 front end
// Accepts input transactions and queues them for the engine.
// ----------------------------------------------------------------------------
module hc128_front import hc128_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire in_t  in_data,
    output logic      q_valid,
    output in_t       q_item,
    input  wire logic q_pop
);

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    in_t            slot_reg [QDEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           push;

    assign in_stall = (count_reg == CW'(QDEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (q_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/hc128_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HC-128 engine
// Runs key setup and keystream steps on the P and Q tables and produces
// one result transaction per queued item.
// ----------------------------------------------------------------------------
module hc128_engine import hc128_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [CFG_W-1:0]  key_low,
    input  wire logic [CFG_W-1:0]  key_high,
    input  wire logic [CFG_W-1:0]  iv_low,
    input  wire logic [CFG_W-1:0]  iv_high,
    input  wire logic              q_valid,
    input  wire in_t               q_item,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output out_t                   out_data
);

    state_t        state_reg, state_next;
    phase_t        ph_reg, ph_next;
    logic [10:0]   sched_reg, sched_next;
    logic [9:0]    count_reg, count_next;
    logic [1:0]    bu_reg, bu_next;
    logic          init_reg, init_next;
    logic          imode_reg, imode_next;
    logic          ov_reg, ov_next;
    out_t          out_reg, out_next;
    logic [7:0]    data_reg, data_next;
    logic [31:0]   ks_reg, ks_next;
    logic [31:0]   a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [31:0]   tn_reg, tn_next, x_reg, x_next, ua_reg, ua_next;
    logic [31:0]   win_reg [16];
    logic [31:0]   win_next [16];

    logic              slot_free;
    logic              emit;
    logic              tsel;
    logic [TBL_AW-1:0] j;
    logic [TBL_AW-1:0] raddr;
    logic [TBL_AW-1:0] waddr;
    logic [31:0]       wdata;
    logic              p_we, q_we;
    logic [31:0]       p_rd, q_rd, t_rd, u_rd;
    logic [31:0]       v;
    logic [31:0]       mix;
    logic [31:0]       word;
    logic [31:0]       ks_byte_src;

    assign slot_free = !ov_reg || !out_stall;
    assign tsel      = count_reg[9];
    assign j         = count_reg[TBL_AW-1:0];
    assign t_rd      = tsel ? q_rd : p_rd;
    assign u_rd      = tsel ? p_rd : q_rd;
    assign mix       = tsel ? mixq(a_reg, b_reg, c_reg) : mixp(a_reg, b_reg, c_reg);
    assign word      = (ua_reg + u_rd) ^ tn_reg;
    assign v         = sig2(win_reg[14]) + win_reg[9] + sig1(win_reg[1]) + win_reg[0]
                     + {21'd0, sched_reg};

    always_comb
    begin
        case (ph_reg)
            PH_RD_A:  raddr = j - TBL_AW'(3);
            PH_RD_B:  raddr = j - TBL_AW'(10);
            PH_RD_C:  raddr = j + TBL_AW'(1);
            PH_RD_T:  raddr = j;
            PH_RD_X:  raddr = j - TBL_AW'(12);
            PH_RD_UA: raddr = {1'b0, x_reg[7:0]};
            PH_RD_UB: raddr = {1'b1, x_reg[23:16]};
            default:  raddr = j;
        endcase
    end

    always_comb
    begin
        p_we  = 1'b0;
        q_we  = 1'b0;
        waddr = j;
        wdata = imode_reg ? word : tn_reg;
        if (state_reg == ST_SCHED)
        begin
            waddr = TBL_AW'(sched_reg - P_FIRST);
            wdata = v;
            p_we  = (sched_reg >= P_FIRST) && (sched_reg < Q_FIRST);
            q_we  = (sched_reg >= Q_FIRST);
        end
        else if (state_reg == ST_STEP && ph_reg == PH_WRITE)
        begin
            p_we = !tsel;
            q_we = tsel;
        end
    end

    hc128_ram #(.WIDTH(WORD_W), .DEPTH(TBL_DEPTH)) u_ram_p (
        .clk   (clk),
        .we    (p_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (p_rd)
    );

    hc128_ram #(.WIDTH(WORD_W), .DEPTH(TBL_DEPTH)) u_ram_q (
        .clk   (clk),
        .we    (q_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (q_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    if (q_item.kind)
                    begin
                        state_next = ST_SCHED;
                    end
                    else if (init_reg && bu_reg == 2'd0)
                    begin
                        state_next = ST_STEP;
                    end
                end
            end
            ST_SCHED:
            begin
                if (sched_reg == SCHED_LAST)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (ph_reg == PH_WRITE && (!imode_reg || count_reg == STEP_LAST))
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop      = 1'b0;
        emit       = 1'b0;
        ph_next    = ph_reg;
        sched_next = sched_reg;
        count_next = count_reg;
        bu_next    = bu_reg;
        init_next  = init_reg;
        imode_next = imode_reg;
        data_next  = data_reg;
        ks_next    = ks_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        tn_next    = tn_reg;
        x_next     = x_reg;
        ua_next    = ua_reg;
        out_next   = out_reg;
        ks_byte_src = ks_reg >> {bu_reg, 3'b000};
        for (int k = 0; k < 16; k++)
        begin
            win_next[k] = win_reg[k];
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop     = 1'b1;
                    data_next = q_item.data_byte;
                    ph_next   = PH_RD_A;
                    if (q_item.kind)
                    begin
                        for (int k = 0; k < 2; k++)
                        begin
                            win_next[4*k]      = key_low[31:0];
                            win_next[4*k + 1]  = key_low[63:32];
                            win_next[4*k + 2]  = key_high[31:0];
                            win_next[4*k + 3]  = key_high[63:32];
                            win_next[4*k + 8]  = iv_low[31:0];
                            win_next[4*k + 9]  = iv_low[63:32];
                            win_next[4*k + 10] = iv_high[31:0];
                            win_next[4*k + 11] = iv_high[63:32];
                        end
                        sched_next = SCHED_FIRST;
                        imode_next = 1'b1;
                    end
                    else if (!init_reg)
                    begin
                        emit     = 1'b1;
                        out_next = '{out_byte: q_item.data_byte, init_done: 1'b0};
                    end
                    else if (bu_reg != 2'd0)
                    begin
                        emit     = 1'b1;
                        out_next = '{out_byte: q_item.data_byte ^ ks_byte_src[7:0],
                                     init_done: 1'b0};
                        bu_next  = bu_reg + 2'd1;
                    end
                    else
                    begin
                        imode_next = 1'b0;
                    end
                end
            end
            ST_SCHED:
            begin
                for (int k = 0; k < 15; k++)
                begin
                    win_next[k] = win_reg[k + 1];
                end
                win_next[15] = v;
                sched_next   = sched_reg + 11'd1;
                if (sched_reg == SCHED_LAST)
                begin
                    count_next = '0;
                    ph_next    = PH_RD_A;
                end
            end
            ST_STEP:
            begin
                ph_next = phase_t'(ph_reg + 4'd1);
                case (ph_reg)
                    PH_RD_B:  a_next  = t_rd;
                    PH_RD_C:  b_next  = t_rd;
                    PH_RD_T:  c_next  = t_rd;
                    PH_RD_X:  tn_next = t_rd + mix;
                    PH_CAP_X: x_next  = t_rd;
                    PH_RD_UB: ua_next = u_rd;
                    PH_WRITE:
                    begin
                        ph_next    = PH_RD_A;
                        count_next = count_reg + 10'd1;
                        if (imode_reg)
                        begin
                            if (count_reg == STEP_LAST)
                            begin
                                emit      = 1'b1;
                                out_next  = '{out_byte: 8'd0, init_done: 1'b1};
                                bu_next   = 2'd0;
                                init_next = 1'b1;
                            end
                        end
                        else
                        begin
                            emit     = 1'b1;
                            ks_next  = word;
                            out_next = '{out_byte: data_reg ^ word[7:0], init_done: 1'b0};
                            bu_next  = 2'd1;
                        end
                    end
                    default: ph_next = phase_t'(ph_reg + 4'd1);
                endcase
            end
            default: ph_next = PH_RD_A;
        endcase
        ov_next = emit ? 1'b1 : (ov_reg && out_stall);
    end

    always_ff @(posedge clk)
    begin
        sched_reg <= sched_next;
        data_reg  <= data_next;
        ks_reg    <= ks_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        tn_reg    <= tn_next;
        x_reg     <= x_next;
        ua_reg    <= ua_next;
        out_reg   <= out_next;
        for (int k = 0; k < 16; k++)
        begin
            win_reg[k] <= win_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ph_reg    <= PH_RD_A;
            count_reg <= '0;
            bu_reg    <= '0;
            init_reg  <= 1'b0;
            imode_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            count_reg <= count_next;
            bu_reg    <= bu_next;
            init_reg  <= init_next;
            imode_reg <= imode_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_IDLE)
        else $error("Queue popped while the engine was busy.");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !(ov_reg && out_stall))
        else $error("Result written over a stalled transaction.");

    a_bytes_init: assert property (@(posedge clk) disable iff (!rst_n)
        bu_reg != 2'd0 |-> init_reg)
        else $error("Keystream bytes in use before key setup.");

    a_sched_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCHED |-> sched_reg >= SCHED_FIRST && sched_reg <= SCHED_LAST)
        else $error("Schedule index out of range.");

endmodule
`default_nettype wire

// File: sv/hc128_stream_cipher_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HC-128 stream cipher top level
// Data bytes are XORed with the keystream; an init transaction runs key setup.
// A data byte passes through the queue and the engine; every fourth keyed
// byte first needs a fresh keystream word from a table step.
// Throughput: one byte per cycle for three bytes of each word while the
// output is not stalled. An init transaction runs the schedule for indices
// 16 to 1279, then 1024 table steps. Reset clears control state; the tables
// are not cleared and data passes through unchanged until the first init.
// ----------------------------------------------------------------------------
module hc128_stream_cipher_top import hc128_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire in_t              in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output out_t                  out_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    logic [CFG_W-1:0] key_low_reg, key_high_reg, iv_low_reg, iv_high_reg;
    logic             q_valid;
    in_t              q_item;
    logic             q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            iv_low_reg   <= '0;
            iv_high_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_IV_LOW:   iv_low_reg   <= cfg_data;
                CFG_IV_HIGH:  iv_high_reg  <= cfg_data;
                default:      key_low_reg  <= key_low_reg;
            endcase
        end
    end

    hc128_front #(.QDEPTH(QDEPTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    hc128_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_low   (key_low_reg),
        .key_high  (key_high_reg),
        .iv_low    (iv_low_reg),
        .iv_high   (iv_high_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

// File: sim/tb_hc128_stream_cipher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HC-128 stream cipher testbench
// Drives key and IV settings, init and data transactions with random gaps and
// stalls, predicts every result with an independent HC-128 model and checks
// each output transaction in order.
// ----------------------------------------------------------------------------
module tb_hc128_stream_cipher_top;
    import hc128_pkg::*;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_INIT = 1'b1;
    localparam int   CYCLE_LIMIT = 1000000;

    class hc128_scoreboard;
        bit [63:0] regs [4];
        bit [31:0] tp [512];
        bit [31:0] tq [512];
        bit [9:0]  step_cnt;
        bit [31:0] ks_word;
        bit [2:0]  used;
        bit        keyed;
        out_t      expected_q [$];
        int        errors;
        int        n_init;
        int        n_data;

        function bit [31:0] ror(bit [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function bit [31:0] advance(bit use_q, int j);
            bit [31:0] a, b, c, m, x, o;
            if (!use_q)
            begin
                a = tp[(j - 3) & 511];
                b = tp[(j - 10) & 511];
                c = tp[(j - 511) & 511];
                m = (ror(a, 10) ^ ror(c, 23)) + ror(b, 8);
                tp[j] = tp[j] + m;
                x = tp[(j - 12) & 511];
                o = (tq[x[7:0]] + tq[256 + x[23:16]]) ^ tp[j];
            end
            else
            begin
                a = tq[(j - 3) & 511];
                b = tq[(j - 10) & 511];
                c = tq[(j - 511) & 511];
                m = (ror(a, 22) ^ ror(c, 9)) + ror(b, 24);
                tq[j] = tq[j] + m;
                x = tq[(j - 12) & 511];
                o = (tp[x[7:0]] + tp[256 + x[23:16]]) ^ tq[j];
            end
            return o;
        endfunction

        function void key_setup();
            bit [31:0] w [16];
            bit [31:0] v, s1, s2;
            for (int k = 0; k < 4; k++)
            begin
                w[k]      = regs[k / 2 + 0][32 * (k % 2) +: 32];
                w[k + 4]  = w[k];
                w[k + 8]  = regs[k / 2 + 2][32 * (k % 2) +: 32];
                w[k + 12] = w[k + 8];
            end
            for (int i = 16; i < 1280; i++)
            begin
                s2 = w[(i - 2) & 15];
                s2 = ror(s2, 17) ^ ror(s2, 19) ^ (s2 >> 10);
                s1 = w[(i - 15) & 15];
                s1 = ror(s1, 7) ^ ror(s1, 18) ^ (s1 >> 3);
                v = s2 + w[(i - 7) & 15] + s1 + w[i & 15] + i;
                w[i & 15] = v;
                if (i >= 256 && i < 768)
                    tp[i - 256] = v;
                else if (i >= 768)
                    tq[i - 768] = v;
            end
            for (int i = 0; i < 512; i++)
                tp[i] = advance(1'b0, i);
            for (int i = 0; i < 512; i++)
                tq[i] = advance(1'b1, i);
            step_cnt = '0;
            used = '0;
            keyed = 1'b1;
        endfunction

        function void note_input(in_t it);
            out_t r;
            bit [7:0] ks;
            r = '0;
            if (it.kind == KIND_INIT)
            begin
                key_setup();
                r.init_done = 1'b1;
                n_init++;
            end
            else if (!keyed)
            begin
                r.out_byte = it.data_byte;
                n_data++;
            end
            else
            begin
                if (used == 0 || used >= 4)
                begin
                    ks_word = advance(step_cnt[9], int'(step_cnt[8:0]));
                    step_cnt = step_cnt + 1'b1;
                    used = 0;
                end
                ks = ks_word[8 * used[1:0] +: 8];
                used = (used + 1) & 3;
                r.out_byte = it.data_byte ^ ks;
                n_data++;
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result out_byte=%02h init_done=%0b",
                         $time, got.out_byte, got.init_done);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $display("%0t: out_byte mismatch expected %02h actual %02h",
                         $time, want.out_byte, got.out_byte);
                errors++;
            end
            if (got.init_done !== want.init_done)
            begin
                $display("%0t: init_done mismatch expected %0b actual %0b",
                         $time, want.init_done, got.init_done);
                errors++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    in_t              in_data = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_t             out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index = CFG_KEY_LOW;
    logic [CFG_W-1:0] cfg_data = '0;

    hc128_scoreboard cipher_sb = new();
    int  idle_mode = 2;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    longint cycles = 0;

    hc128_stream_cipher_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            cipher_sb.check_result(out_data);
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (idle_mode == 0)
            out_stall <= ($urandom_range(99) < 65);
        else if (idle_mode == 1)
            out_stall <= ($urandom_range(99) < 24);
        else
            out_stall <= 1'b0;
    end

    task automatic send_item(input logic kind, input logic [7:0] value);
        in_t it;
        int  pct;
        it.kind = kind;
        it.data_byte = value;
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        cipher_sb.note_input(it);
        pct = (idle_mode == 0) ? 24 : (idle_mode == 1) ? 65 : 0;
        if ($urandom_range(99) < pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (cipher_sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (16)
            @(posedge clk);
    endtask

    task automatic load_key(input logic [63:0] k_lo, input logic [63:0] k_hi,
                            input logic [63:0] v_lo, input logic [63:0] v_hi);
        logic [63:0] vals [4];
        logic [1:0]  idx [4];
        vals = '{k_lo, k_hi, v_lo, v_hi};
        idx = '{CFG_KEY_LOW, CFG_KEY_HIGH, CFG_IV_LOW, CFG_IV_HIGH};
        for (int r = 0; r < 4; r++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[r];
            cfg_data <= vals[r];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cipher_sb.regs[idx[r]] = vals[r];
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_traffic(input int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(199) == 0)
                send_item(KIND_INIT, 8'($urandom));
            else
                send_item(KIND_DATA, 8'($urandom));
        end
    endtask

    initial
    begin
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_mode = 0;
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_DATA, 8'hA5);
        send_item(KIND_DATA, 8'h5A);
        wait_drained();

        load_key('0, '0, '0, '0);
        send_item(KIND_INIT, 8'hFF);
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_DATA, 8'hFF);
        for (int n = 0; n < 10; n++)
            send_item(KIND_DATA, 8'($urandom));
        send_item(KIND_INIT, 8'h00);
        send_item(KIND_INIT, 8'h3C);
        send_item(KIND_DATA, 8'h80);
        send_item(KIND_DATA, 8'h01);
        wait_drained();

        load_key('1, '1, '1, '1);
        send_item(KIND_INIT, 8'h00);
        for (int n = 0; n < 700; n++)
            send_item(KIND_DATA, 8'($urandom));
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            idle_mode = ph % 3;
            load_key({$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
            send_item(KIND_INIT, 8'($urandom));
            if (ph == 2)
            begin
                wait_drained();
                hold_req = 1'b1;
                for (int n = 0; n < 40; n++)
                    send_item(KIND_DATA, 8'($urandom));
            end
            random_traffic(115);
            wait_drained();
        end

        $display("Covered %0d init and %0d data transactions over eight key settings,",
                 cipher_sb.n_init, cipher_sb.n_data);
        $display("including pass-through before keying and back-to-back re-keying.");
        if (cipher_sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// File: filelist.f
sv/hc128_pkg.sv
sv/hc128_ram.sv
sv/hc128_front.sv
sv/hc128_engine.sv
sv/hc128_stream_cipher_top.sv
sim/tb_hc128_stream_cipher_top.sv
